@@ src/sst_pkg.sv @@
// Shared types and constants for the sparse set table.
package sst_pkg;

   // Default sizes of the table.
   localparam int DEF_ID_SPACE      = 4096;
   localparam int DEF_CAPACITY      = 256;
   localparam int DEF_PAYLOAD_WIDTH = 32;

   // Fixed widths of the request and response fields.
   localparam int ID_BITS     = 12;
   localparam int SLOT_BITS   = 8;
   localparam int PAY_BITS    = 32;
   localparam int COUNT_BITS  = 9;
   localparam int STATUS_BITS = 3;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_INSERT      = 2'd0,
      REQ_FIND        = 2'd1,
      REQ_REMOVE_SLOT = 2'd2,
      REQ_REMOVE_ID   = 2'd3
   } req_kind_type;

   // Response status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_DUP       = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_SLOT  = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_READ,
      S_MOVE,
      S_FIX,
      S_OUT
   } state_type;

endpackage

@@ src/sst_dir_ram.sv @@
// Directory memory: one write port and one registered read port.
module sst_dir_ram #(
   parameter int DEPTH = sst_pkg::DEF_ID_SPACE,
   parameter int AW    = 12,
   parameter int DW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sst_slot_ram.sv @@
// Slot memory holding id and payload: one write port, two registered read ports.
module sst_slot_ram #(
   parameter int DEPTH = sst_pkg::DEF_CAPACITY,
   parameter int AW    = 8,
   parameter int DW    = 44
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr_a,
   output logic [DW-1:0] rd_data_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_a_ff;
   logic [DW-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Both read ports, data registered.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/sparse_set_table.sv @@
// Sparse set table: directory and dense slot memories under one request sequencer.
// Request to response: insert passes S_LOOK, S_OUT; find S_LOOK, S_READ, S_OUT;
// remove S_LOOK, S_MOVE, S_FIX (entry moved only), S_OUT; a failed one S_LOOK, S_OUT.
// One request is in work at a time; the registered memory reads set these states.
// After reset the directory is cleared one word a cycle, all ID_SPACE words,
// with req_stall high; then the table is empty and the live count is zero.
module sparse_set_table #(
   parameter int ID_SPACE      = sst_pkg::DEF_ID_SPACE,
   parameter int CAPACITY      = sst_pkg::DEF_CAPACITY,
   parameter int PAYLOAD_WIDTH = sst_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [sst_pkg::ID_BITS-1:0]        req_entry_id,
   input  logic [sst_pkg::SLOT_BITS-1:0]      req_slot_index,
   input  logic [sst_pkg::PAY_BITS-1:0]       req_entry_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sst_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [sst_pkg::SLOT_BITS-1:0]      rsp_result_slot,
   output logic [sst_pkg::PAY_BITS-1:0]       rsp_result_payload,
   output logic [sst_pkg::COUNT_BITS-1:0]     rsp_live_count
);

   localparam int DIR_AW  = $clog2(ID_SPACE);
   localparam int SLOT_AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int DIR_W   = SLOT_AW + 1;
   localparam int IDW     = sst_pkg::ID_BITS;
   localparam int SLOT_DW = IDW + PAYLOAD_WIDTH;

   // Sequencer and request registers.
   sst_pkg::state_type    state_ff, state_in;
   sst_pkg::req_kind_type kind_ff, kind_in;
   logic [IDW-1:0]                    id_ff, id_in;
   logic [sst_pkg::SLOT_BITS-1:0]     sidx_ff, sidx_in;
   logic [PAYLOAD_WIDTH-1:0]          pay_ff, pay_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [DIR_AW-1:0]                 clr_ff, clr_in;
   logic [SLOT_AW-1:0]                pos_ff, pos_in;
   logic [IDW-1:0]                    moved_ff, moved_in;

   // Pending result and response registers.
   sst_pkg::status_type               res_status_ff, res_status_in;
   logic [SLOT_AW-1:0]                res_slot_ff, res_slot_in;
   logic [PAYLOAD_WIDTH-1:0]          res_pay_ff, res_pay_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sst_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [sst_pkg::SLOT_BITS-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [sst_pkg::PAY_BITS-1:0]      rsp_pay_ff, rsp_pay_in;
   logic [sst_pkg::COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                dir_we;
   logic [DIR_AW-1:0]   dir_waddr;
   logic [DIR_W-1:0]    dir_wdata;
   logic [DIR_AW-1:0]   dir_raddr;
   logic [DIR_W-1:0]    dir_rdata;
   logic                slot_we;
   logic [SLOT_AW-1:0]  slot_waddr;
   logic [SLOT_DW-1:0]  slot_wdata;
   logic [SLOT_AW-1:0]  slot_raddr_a;
   logic [SLOT_AW-1:0]  slot_raddr_b;
   logic [SLOT_DW-1:0]  slot_rdata_a;
   logic [SLOT_DW-1:0]  slot_rdata_b;

   // Decoded lookup values.
   logic                req_take;
   logic                out_free;
   logic                id_in_range;
   logic [SLOT_AW-1:0]  where;
   logic                live;
   logic [SLOT_AW-1:0]  last;
   logic                sidx_ok;
   logic                table_full;
   logic [IDW-1:0]      gone_id;
   logic [IDW-1:0]      move_id;

   sst_dir_ram #(
      .DEPTH (ID_SPACE),
      .AW    (DIR_AW),
      .DW    (DIR_W)
   ) u_dir (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_addr (dir_raddr),
      .rd_data (dir_rdata)
   );

   sst_slot_ram #(
      .DEPTH (CAPACITY),
      .AW    (SLOT_AW),
      .DW    (SLOT_DW)
   ) u_slot (
      .clock     (clock),
      .wr_en     (slot_we),
      .wr_addr   (slot_waddr),
      .wr_data   (slot_wdata),
      .rd_addr_a (slot_raddr_a),
      .rd_data_a (slot_rdata_a),
      .rd_addr_b (slot_raddr_b),
      .rd_data_b (slot_rdata_b)
   );

   // A request is taken when idle, or when the last result leaves this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == sst_pkg::S_IDLE) ||
                        ((state_ff == sst_pkg::S_OUT) && out_free));
   assign req_take  = req_valid && !req_stall;

   // Directory word of the request id, valid in the lookup state.
   assign id_in_range = 32'(id_ff) < ID_SPACE;
   assign where       = dir_rdata[SLOT_AW-1:0];
   assign live        = id_in_range && dir_rdata[SLOT_AW] &&
                        (32'(where) < 32'(count_ff));
   assign last        = SLOT_AW'(count_ff - CNT_W'(1));
   assign sidx_ok     = 32'(sidx_ff) < 32'(count_ff);
   assign table_full  = 32'(count_ff) >= CAPACITY;

   // Ids read from the slot memory during a removal.
   assign gone_id = slot_rdata_a[SLOT_DW-1:PAYLOAD_WIDTH];
   assign move_id = slot_rdata_b[SLOT_DW-1:PAYLOAD_WIDTH];

   // Directory read address: the incoming id at transfer, else the held id.
   assign dir_raddr = req_take ? DIR_AW'(req_entry_id) : DIR_AW'(id_ff);

   // Slot reads: port A the target slot, port B the last live slot.
   assign slot_raddr_a = (kind_ff == sst_pkg::REQ_REMOVE_SLOT) ? SLOT_AW'(sidx_ff) : where;
   assign slot_raddr_b = last;

   // Next state, memory writes and result capture.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      sidx_in       = sidx_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      moved_in      = moved_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_count_in  = rsp_count_ff;
      dir_we        = 1'b0;
      dir_waddr     = DIR_AW'(id_ff);
      dir_wdata     = '0;
      slot_we       = 1'b0;
      slot_waddr    = pos_ff;
      slot_wdata    = slot_rdata_b;

      // The response register drains independently of the sequencer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sst_pkg::S_CLEAR: begin
            dir_we    = 1'b1;
            dir_waddr = clr_ff;
            dir_wdata = '0;
            clr_in    = clr_ff + DIR_AW'(1);
            if (32'(clr_ff) == ID_SPACE - 1) begin
               state_in = sst_pkg::S_IDLE;
            end
         end

         sst_pkg::S_IDLE: begin
         end

         sst_pkg::S_LOOK: begin
            res_status_in = sst_pkg::ST_OK;
            res_slot_in   = '0;
            res_pay_in    = '0;
            state_in      = sst_pkg::S_OUT;
            case (kind_ff)
               sst_pkg::REQ_INSERT: begin
                  if (live) begin
                     res_status_in = sst_pkg::ST_DUP;
                  end else if (!id_in_range || table_full) begin
                     res_status_in = sst_pkg::ST_FULL;
                  end else begin
                     slot_we     = 1'b1;
                     slot_waddr  = SLOT_AW'(count_ff);
                     slot_wdata  = {id_ff, pay_ff};
                     dir_we      = 1'b1;
                     dir_waddr   = DIR_AW'(id_ff);
                     dir_wdata   = {1'b1, SLOT_AW'(count_ff)};
                     res_slot_in = SLOT_AW'(count_ff);
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               sst_pkg::REQ_FIND: begin
                  if (!live) begin
                     res_status_in = sst_pkg::ST_NOT_FOUND;
                  end else begin
                     pos_in   = where;
                     state_in = sst_pkg::S_READ;
                  end
               end
               sst_pkg::REQ_REMOVE_SLOT: begin
                  if (!sidx_ok) begin
                     res_status_in = sst_pkg::ST_BAD_SLOT;
                  end else begin
                     pos_in   = SLOT_AW'(sidx_ff);
                     state_in = sst_pkg::S_MOVE;
                  end
               end
               default: begin
                  if (!live) begin
                     res_status_in = sst_pkg::ST_NOT_FOUND;
                  end else begin
                     pos_in   = where;
                     state_in = sst_pkg::S_MOVE;
                  end
               end
            endcase
         end

         // Payload of the found slot arrives from read port A.
         sst_pkg::S_READ: begin
            res_slot_in = pos_ff;
            res_pay_in  = slot_rdata_a[PAYLOAD_WIDTH-1:0];
            state_in    = sst_pkg::S_OUT;
         end

         // Empty the removed id and move the last entry into the freed slot.
         sst_pkg::S_MOVE: begin
            res_slot_in = pos_ff;
            count_in    = count_ff - CNT_W'(1);
            if (32'(gone_id) < ID_SPACE) begin
               dir_we    = 1'b1;
               dir_waddr = DIR_AW'(gone_id);
               dir_wdata = '0;
            end
            if (pos_ff != last) begin
               slot_we    = 1'b1;
               slot_waddr = pos_ff;
               slot_wdata = slot_rdata_b;
               moved_in   = move_id;
               state_in   = sst_pkg::S_FIX;
            end else begin
               state_in   = sst_pkg::S_OUT;
            end
         end

         // Point the moved entry's directory word at its new slot.
         sst_pkg::S_FIX: begin
            if (32'(moved_ff) < ID_SPACE) begin
               dir_we    = 1'b1;
               dir_waddr = DIR_AW'(moved_ff);
               dir_wdata = {1'b1, pos_ff};
            end
            state_in = sst_pkg::S_OUT;
         end

         sst_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = sst_pkg::SLOT_BITS'(res_slot_ff);
               rsp_pay_in    = sst_pkg::PAY_BITS'(res_pay_ff);
               rsp_count_in  = sst_pkg::COUNT_BITS'(count_ff);
               state_in      = sst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase

      // Capture a new request on transfer; its directory read is under way.
      if (req_take) begin
         kind_in  = sst_pkg::req_kind_type'(req_type);
         id_in    = req_entry_id;
         sidx_in  = req_slot_index;
         pay_in   = PAYLOAD_WIDTH'(req_entry_payload);
         state_in = sst_pkg::S_LOOK;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      sidx_ff       <= sidx_in;
      pay_ff        <= pay_in;
      pos_ff        <= pos_in;
      moved_ff      <= moved_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_slot    = rsp_slot_ff;
   assign rsp_result_payload = rsp_pay_ff;
   assign rsp_live_count     = rsp_count_ff;

endmodule

@@ tb/sst_checker.sv @@
// Scoreboard for the sparse set table: predicts each response and checks it on transfer.
`timescale 1ns / 1ps

module sst_checker #(
   parameter int ID_SPACE      = sst_pkg::DEF_ID_SPACE,
   parameter int CAPACITY      = sst_pkg::DEF_CAPACITY,
   parameter int PAYLOAD_WIDTH = sst_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [sst_pkg::ID_BITS-1:0]     req_entry_id,
   input  logic [sst_pkg::SLOT_BITS-1:0]   req_slot_index,
   input  logic [sst_pkg::PAY_BITS-1:0]    req_entry_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sst_pkg::STATUS_BITS-1:0] rsp_status,
   input  logic [sst_pkg::SLOT_BITS-1:0]   rsp_result_slot,
   input  logic [sst_pkg::PAY_BITS-1:0]    rsp_result_payload,
   input  logic [sst_pkg::COUNT_BITS-1:0]  rsp_live_count,
   output int                              fail_count,
   output int                              pending
);

   // Only the low PAYLOAD_WIDTH bits of a payload are kept.
   localparam int KEEP_BITS = (PAYLOAD_WIDTH < sst_pkg::PAY_BITS) ?
                              PAYLOAD_WIDTH : sst_pkg::PAY_BITS;
   localparam logic [sst_pkg::PAY_BITS-1:0] PAY_MASK =
      {sst_pkg::PAY_BITS{1'b1}} >> (sst_pkg::PAY_BITS - KEEP_BITS);

   typedef struct {
      sst_pkg::status_type                status;
      logic [sst_pkg::SLOT_BITS-1:0]      slot;
      logic [sst_pkg::PAY_BITS-1:0]       payload;
      logic [sst_pkg::COUNT_BITS-1:0]     count;
   } table_answer_type;

   // Shadow copy of the directory and the dense slots.
   bit                           dir_live [ID_SPACE];
   int unsigned                  dir_slot [ID_SPACE];
   logic [sst_pkg::ID_BITS-1:0]  slot_id  [CAPACITY];
   logic [sst_pkg::PAY_BITS-1:0] slot_pay [CAPACITY];
   int unsigned                  live_entries;

   table_answer_type             answer_q[$];

   // Swap-remove: the last live entry fills the freed slot.
   task automatic drop_slot(input int unsigned s);
      int unsigned gone;
      int unsigned last;
      int unsigned moved;
      gone = 32'(slot_id[s]);
      last = live_entries - 1;
      if (gone < ID_SPACE) dir_live[gone] = 1'b0;
      if (s != last) begin
         moved       = 32'(slot_id[last]);
         slot_id[s]  = slot_id[last];
         slot_pay[s] = slot_pay[last];
         if (moved < ID_SPACE) dir_slot[moved] = s;
      end
      live_entries = last;
   endtask

   // Apply one request to the shadow table and work out its response.
   task automatic apply_request(input logic [1:0] kind,
                                input logic [sst_pkg::ID_BITS-1:0] id,
                                input logic [sst_pkg::SLOT_BITS-1:0] sidx,
                                input logic [sst_pkg::PAY_BITS-1:0] pay,
                                output table_answer_type ans);
      bit          live;
      int unsigned where;
      ans.status  = sst_pkg::ST_OK;
      ans.slot    = '0;
      ans.payload = '0;
      live        = 1'b0;
      where       = 0;
      if (32'(id) < ID_SPACE) begin
         live  = dir_live[id];
         where = dir_slot[id];
         if (live && where >= live_entries) live = 1'b0;
      end
      case (sst_pkg::req_kind_type'(kind))
         sst_pkg::REQ_INSERT: begin
            if (live) begin
               ans.status = sst_pkg::ST_DUP;
            end else if (32'(id) >= ID_SPACE || live_entries >= CAPACITY) begin
               ans.status = sst_pkg::ST_FULL;
            end else begin
               ans.slot               = live_entries[sst_pkg::SLOT_BITS-1:0];
               slot_id[live_entries]  = id;
               slot_pay[live_entries] = pay & PAY_MASK;
               dir_slot[id]           = live_entries;
               dir_live[id]           = 1'b1;
               live_entries++;
            end
         end
         sst_pkg::REQ_FIND: begin
            if (!live) begin
               ans.status = sst_pkg::ST_NOT_FOUND;
            end else begin
               ans.slot    = where[sst_pkg::SLOT_BITS-1:0];
               ans.payload = slot_pay[where];
            end
         end
         sst_pkg::REQ_REMOVE_SLOT: begin
            if (32'(sidx) >= live_entries) begin
               ans.status = sst_pkg::ST_BAD_SLOT;
            end else begin
               ans.slot = sidx;
               drop_slot(32'(sidx));
            end
         end
         default: begin
            if (!live) begin
               ans.status = sst_pkg::ST_NOT_FOUND;
            end else begin
               ans.slot = where[sst_pkg::SLOT_BITS-1:0];
               drop_slot(where);
            end
         end
      endcase
      ans.count = live_entries[sst_pkg::COUNT_BITS-1:0];
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      table_answer_type want;
      table_answer_type got;
      if (reset) begin
         for (int i = 0; i < ID_SPACE; i++) begin
            dir_live[i] = 1'b0;
            dir_slot[i] = 0;
         end
         for (int i = 0; i < CAPACITY; i++) begin
            slot_id[i]  = '0;
            slot_pay[i] = '0;
         end
         live_entries = 0;
         answer_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_result_slot !== want.slot) begin
                  $error("result_slot: expected %0d, actual %0d", want.slot, rsp_result_slot);
                  fail_count++;
               end
               if (rsp_result_payload !== want.payload) begin
                  $error("result_payload: expected %h, actual %h", want.payload,
                         rsp_result_payload);
                  fail_count++;
               end
               if (rsp_live_count !== want.count) begin
                  $error("live_count: expected %0d, actual %0d", want.count, rsp_live_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_type, req_entry_id, req_slot_index, req_entry_payload, got);
            answer_q.push_back(got);
         end
      end
      pending = answer_q.size();
   end

endmodule

@@ tb/tb_sparse_set_table.sv @@
// Testbench top for the sparse set table: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module tb_sparse_set_table;

   localparam int ID_SPACE      = sst_pkg::DEF_ID_SPACE;
   localparam int CAPACITY      = sst_pkg::DEF_CAPACITY;
   localparam int PAYLOAD_WIDTH = sst_pkg::DEF_PAYLOAD_WIDTH;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int MAX_GROW      = 600;
   localparam int FULL_ITEMS    = 40;
   localparam int DRAIN_ITEMS   = 130;

   typedef enum {PH_GROW, PH_FULL, PH_DRAIN} phase_type;
   typedef enum {
      PICK_NEW_INSERT, PICK_DUP_INSERT, PICK_FIND_LIVE, PICK_FIND_ANY,
      PICK_DROP_SLOT, PICK_DROP_LIVE, PICK_DROP_ANY_ID, PICK_DROP_ANY_SLOT
   } pick_type;
   typedef enum {RX_FLOW, RX_RANDOM, RX_HOLD, RX_TOGGLE} rx_mode_type;

   logic                               clock;
   logic                               reset             = 1'b1;
   logic                               req_valid         = 1'b0;
   logic                               req_stall;
   logic [1:0]                         req_type          = sst_pkg::REQ_INSERT;
   logic [sst_pkg::ID_BITS-1:0]        req_entry_id      = '0;
   logic [sst_pkg::SLOT_BITS-1:0]      req_slot_index    = '0;
   logic [sst_pkg::PAY_BITS-1:0]       req_entry_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall         = 1'b0;
   logic [sst_pkg::STATUS_BITS-1:0]    rsp_status;
   logic [sst_pkg::SLOT_BITS-1:0]      rsp_result_slot;
   logic [sst_pkg::PAY_BITS-1:0]       rsp_result_payload;
   logic [sst_pkg::COUNT_BITS-1:0]     rsp_live_count;
   int                                 fail_count;
   int                                 pending;

   // Ids believed live, kept in dense order so slot picks land on real entries.
   logic [sst_pkg::ID_BITS-1:0]        pool[$];
   bit                                 pooled [ID_SPACE];
   int                                 burst_left;
   int                                 cycles = 0;

   sparse_set_table #(
      .ID_SPACE(ID_SPACE), .CAPACITY(CAPACITY), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_entry_id(req_entry_id), .req_slot_index(req_slot_index),
      .req_entry_payload(req_entry_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_result_slot(rsp_result_slot), .rsp_result_payload(rsp_result_payload),
      .rsp_live_count(rsp_live_count)
   );

   sst_checker #(
      .ID_SPACE(ID_SPACE), .CAPACITY(CAPACITY), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
   ) scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_entry_id(req_entry_id), .req_slot_index(req_slot_index),
      .req_entry_payload(req_entry_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_result_slot(rsp_result_slot), .rsp_result_payload(rsp_result_payload),
      .rsp_live_count(rsp_live_count),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver back-pressure: free flow, random, long holds and toggling, in runs.
   always @(posedge clock) begin
      static rx_mode_type rx_mode = RX_FLOW;
      static int          rx_run  = 0;
      if (rx_run == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_run  = $urandom_range(10, 80);
      end
      rx_run--;
      case (rx_mode)
         RX_FLOW:   rsp_stall <= 1'b0;
         RX_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
         RX_HOLD:   rsp_stall <= (rx_run % 31) != 0;
         default:   rsp_stall <= ~rsp_stall;
      endcase
   end

   function automatic int new_burst();
      return ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
   endfunction

   // Present one request, hold it until the transfer, then pace the sender.
   task automatic send_request(input sst_pkg::req_kind_type kind,
                               input logic [sst_pkg::ID_BITS-1:0] id,
                               input logic [sst_pkg::SLOT_BITS-1:0] sidx,
                               input logic [sst_pkg::PAY_BITS-1:0] pay);
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_entry_id      <= id;
      req_slot_index    <= sidx;
      req_entry_payload <= pay;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = new_burst();
      end
   endtask

   task automatic pool_drop(input int idx);
      pooled[pool[idx]] = 1'b0;
      pool[idx] = pool[pool.size() - 1];
      void'(pool.pop_back());
   endtask

   // Send a request and keep the id pool in step with its likely effect.
   task automatic issue(input sst_pkg::req_kind_type kind,
                        input logic [sst_pkg::ID_BITS-1:0] id,
                        input logic [sst_pkg::SLOT_BITS-1:0] sidx,
                        input logic [sst_pkg::PAY_BITS-1:0] pay);
      send_request(kind, id, sidx, pay);
      case (kind)
         sst_pkg::REQ_INSERT: begin
            if (!pooled[id] && pool.size() < CAPACITY) begin
               pool.push_back(id);
               pooled[id] = 1'b1;
            end
         end
         sst_pkg::REQ_REMOVE_SLOT: begin
            if (32'(sidx) < pool.size()) pool_drop(int'(sidx));
         end
         sst_pkg::REQ_REMOVE_ID: begin
            if (pooled[id]) begin
               for (int i = 0; i < pool.size(); i++) begin
                  if (pool[i] == id) begin
                     pool_drop(i);
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // One random request, weighted by the phase of the run.
   task automatic random_request(input phase_type phase);
      int                            r;
      pick_type                      pick;
      sst_pkg::req_kind_type         kind;
      logic [sst_pkg::ID_BITS-1:0]   id;
      logic [sst_pkg::SLOT_BITS-1:0] sidx;
      logic [sst_pkg::PAY_BITS-1:0]  pay;
      r    = $urandom_range(0, 99);
      id   = sst_pkg::ID_BITS'($urandom_range(0, ID_SPACE - 1));
      sidx = sst_pkg::SLOT_BITS'($urandom_range(0, 255));
      pay  = $urandom();
      case (phase)
         PH_GROW: begin
            if      (r < 86) pick = PICK_NEW_INSERT;
            else if (r < 89) pick = PICK_DUP_INSERT;
            else if (r < 94) pick = PICK_FIND_LIVE;
            else if (r < 96) pick = PICK_FIND_ANY;
            else if (r < 98) pick = PICK_DROP_SLOT;
            else if (r < 99) pick = PICK_DROP_LIVE;
            else             pick = PICK_DROP_ANY_SLOT;
         end
         PH_FULL: begin
            if      (r < 30) pick = PICK_NEW_INSERT;
            else if (r < 40) pick = PICK_DUP_INSERT;
            else if (r < 55) pick = PICK_FIND_LIVE;
            else if (r < 62) pick = PICK_FIND_ANY;
            else if (r < 75) pick = PICK_DROP_SLOT;
            else if (r < 88) pick = PICK_DROP_LIVE;
            else if (r < 94) pick = PICK_DROP_ANY_ID;
            else             pick = PICK_DROP_ANY_SLOT;
         end
         default: begin
            if      (r < 40) pick = PICK_DROP_SLOT;
            else if (r < 75) pick = PICK_DROP_LIVE;
            else if (r < 85) pick = PICK_FIND_LIVE;
            else if (r < 90) pick = PICK_NEW_INSERT;
            else if (r < 93) pick = PICK_FIND_ANY;
            else if (r < 96) pick = PICK_DROP_ANY_ID;
            else             pick = PICK_DROP_ANY_SLOT;
         end
      endcase
      // Picks that need a live entry fall back to a random id or slot on an empty pool.
      case (pick)
         PICK_NEW_INSERT: begin
            kind = sst_pkg::REQ_INSERT;
            repeat (8) begin
               if (pooled[id]) id = sst_pkg::ID_BITS'($urandom_range(0, ID_SPACE - 1));
            end
         end
         PICK_DUP_INSERT: begin
            kind = sst_pkg::REQ_INSERT;
            if (pool.size() > 0) id = pool[$urandom_range(0, pool.size() - 1)];
         end
         PICK_FIND_LIVE: begin
            kind = sst_pkg::REQ_FIND;
            if (pool.size() > 0) id = pool[$urandom_range(0, pool.size() - 1)];
         end
         PICK_FIND_ANY: kind = sst_pkg::REQ_FIND;
         PICK_DROP_SLOT: begin
            kind = sst_pkg::REQ_REMOVE_SLOT;
            if (pool.size() > 0) begin
               if ($urandom_range(0, 4) == 0) begin
                  sidx = sst_pkg::SLOT_BITS'(pool.size() - 1);
               end else begin
                  sidx = sst_pkg::SLOT_BITS'($urandom_range(0, pool.size() - 1));
               end
            end
         end
         PICK_DROP_LIVE: begin
            kind = sst_pkg::REQ_REMOVE_ID;
            if (pool.size() > 0) id = pool[$urandom_range(0, pool.size() - 1)];
         end
         PICK_DROP_ANY_ID: kind = sst_pkg::REQ_REMOVE_ID;
         default: kind = sst_pkg::REQ_REMOVE_SLOT;
      endcase
      issue(kind, id, sidx, pay);
   endtask

   initial begin
      int grown;
      burst_left = new_burst();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, both id extremes, duplicates, bad slots and swap moves.
      issue(sst_pkg::REQ_FIND,        12'd0,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_SLOT, 12'd0,    8'd0,   32'hFFFF_FFFF);
      issue(sst_pkg::REQ_REMOVE_ID,   12'hFFF,  8'd255, 32'h0000_0000);
      issue(sst_pkg::REQ_INSERT,      12'd0,    8'd255, 32'h0000_0000);
      issue(sst_pkg::REQ_INSERT,      12'hFFF,  8'd0,   32'hFFFF_FFFF);
      issue(sst_pkg::REQ_INSERT,      12'd0,    8'd0,   32'h1234_5678);
      issue(sst_pkg::REQ_FIND,        12'hFFF,  8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_FIND,        12'd0,    8'd0,   32'hFFFF_FFFF);
      issue(sst_pkg::REQ_REMOVE_SLOT, 12'd0,    8'd255, 32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_SLOT, 12'd0,    8'd2,   32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_ID,   12'd0,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_FIND,        12'hFFF,  8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_FIND,        12'd0,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_SLOT, 12'd0,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_INSERT,      12'd7,    8'd0,   32'hA5A5_A5A5);
      issue(sst_pkg::REQ_INSERT,      12'd8,    8'd0,   32'h5A5A_5A5A);
      issue(sst_pkg::REQ_INSERT,      12'd9,    8'd0,   32'h8000_0001);
      issue(sst_pkg::REQ_REMOVE_SLOT, 12'd0,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_FIND,        12'd9,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_ID,   12'd8,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_ID,   12'd9,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_REMOVE_ID,   12'd9,    8'd0,   32'h0000_0000);
      issue(sst_pkg::REQ_FIND,        12'd7,    8'd0,   32'h0000_0000);

      // Random: fill the table toward capacity (at most MAX_GROW requests), work it, then drain it.
      grown = 0;
      while (pool.size() < CAPACITY && grown < MAX_GROW) begin
         random_request(PH_GROW);
         grown++;
      end
      repeat (FULL_ITEMS) random_request(PH_FULL);
      repeat (DRAIN_ITEMS) random_request(PH_DRAIN);

      // Let the last responses arrive, then wait out any stragglers.
      // The wait starts on a clock edge so the scoreboard has counted the final transfer.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/sst_pkg.sv
src/sst_dir_ram.sv
src/sst_slot_ram.sv
src/sparse_set_table.sv
tb/sst_checker.sv
tb/tb_sparse_set_table.sv
